[rtl/core/steering_force_feedback_loop_top_assert.svh]
// ----------------------------------------------------------------------------
// Steering force feedback loop - assertion macros
// Concurrent property shorthands shared by the checker.
// ----------------------------------------------------------------------------
`ifndef STEERING_FORCE_FEEDBACK_LOOP_TOP_ASSERT_SVH
`define STEERING_FORCE_FEEDBACK_LOOP_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFFL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SFFL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/sffl_pkg.sv]
// ----------------------------------------------------------------------------
// Steering force feedback loop - package
// Field widths, stream packing offsets, datapath widths, register indexes.
// ----------------------------------------------------------------------------
package sffl_pkg;

  // item fields
  localparam int unsigned POS_W   = 32;
  localparam int unsigned SPD_W   = 24;
  localparam int unsigned ELA_W   = 17;
  localparam int unsigned NOISE_W = 16;
  localparam int unsigned OUT_W   = 32;

  // tdata packing, first field in the low bits
  localparam int unsigned POS_LSB     = 0;
  localparam int unsigned SPD_LSB     = POS_LSB + POS_W;
  localparam int unsigned ELA_LSB     = SPD_LSB + SPD_W;
  localparam int unsigned NOISE_LSB   = ELA_LSB + ELA_W;
  localparam int unsigned IN_TDATA_W  = 96;
  localparam int unsigned OUT_TDATA_W = 32;

  // configuration
  localparam int unsigned GAIN_W    = 24;
  localparam int unsigned RUMB_W    = 20;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPRING_GAIN  = 2'd0,
    CFG_DAMPING_GAIN = 2'd1,
    CFG_DRIFT_GAIN   = 2'd2,
    CFG_RUMBLE_AMP   = 2'd3
  } cfg_idx_e;

  // elasticity of one in Q1.16
  localparam logic [ELA_W-1:0] ELA_ONE = 17'h1_0000;

  // shared multiplier
  localparam int unsigned MUL_A_W = 33;
  localparam int unsigned MUL_B_W = 24;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // damping divider: 40-bit dividend, 4 quotient bits a cycle
  localparam int unsigned DIV_W     = 40;
  localparam int unsigned DIV_DIGIT = 4;
  localparam int unsigned DIV_STEPS = DIV_W / DIV_DIGIT;

  // term accumulator
  localparam int unsigned ACC_W = 46;

  // window control from the sequencer
  typedef struct packed {
    logic rd;   // fetch the oldest sample
    logic upd;  // replace it and update the running sum
  } win_ctrl_t;

endpackage

[rtl/core/sffl_window.sv]
// ----------------------------------------------------------------------------
// Steering force feedback loop - speed window
// Circular sample store with running sum; unwritten slots read as zero.
// ----------------------------------------------------------------------------
module sffl_window
  import sffl_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = 50,
  localparam int unsigned SumW = SPD_W + $clog2(WINDOW_LEN) + 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  win_ctrl_t              ctrl_i,
  input  logic [SPD_W-1:0]       spd_i,
  output logic signed [SumW-1:0] sum_o
);

  localparam int unsigned PtrW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

  logic [SPD_W-1:0]       mem_q [WINDOW_LEN];
  logic [WINDOW_LEN-1:0]  vld_q;
  logic [SPD_W-1:0]       rd_q;
  logic                   rd_vld_q;
  logic [PtrW-1:0]        ptr_q, ptr_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic signed [SumW-1:0] old_ext, new_ext;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd) begin
      rd_q <= mem_q[ptr_q];
    end
    if (ctrl_i.upd) begin
      mem_q[ptr_q] <= spd_i;
    end
  end

  assign old_ext = rd_vld_q ? SumW'($signed(rd_q)) : '0;
  assign new_ext = SumW'($signed(spd_i));
  assign sum_d   = sum_q + new_ext - old_ext;
  assign ptr_d   = (ptr_q == PtrW'(WINDOW_LEN - 1)) ? '0 : ptr_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      ptr_q    <= '0;
      sum_q    <= '0;
    end else begin
      if (ctrl_i.rd) begin
        rd_vld_q <= vld_q[ptr_q];
      end
      if (ctrl_i.upd) begin
        vld_q[ptr_q] <= 1'b1;
        ptr_q        <= ptr_d;
        sum_q        <= sum_d;
      end
    end
  end

  assign sum_o = sum_q;

endmodule

[rtl/core/sffl_mul.sv]
// ----------------------------------------------------------------------------
// Steering force feedback loop - shared multiplier
// Unsigned 33 x 24 multiply with registered product.
// ----------------------------------------------------------------------------
module sffl_mul
  import sffl_pkg::*;
(
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [MUL_A_W-1:0] a_i,
  input  logic [MUL_B_W-1:0] b_i,
  output logic [MUL_P_W-1:0] p_o
);

  logic [MUL_P_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= MUL_P_W'(a_i) * MUL_P_W'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

[rtl/core/sffl_div.sv]
// ----------------------------------------------------------------------------
// Steering force feedback loop - constant divider
// Restoring division by a fixed divisor, DIV_DIGIT quotient bits a cycle.
// ----------------------------------------------------------------------------
module sffl_div
  import sffl_pkg::*;
#(
  parameter int unsigned DIVISOR = 50
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  output logic [DIV_W-1:0] quo_o,
  output logic             done_o
);

  localparam int unsigned RemW = $clog2(DIVISOR + 1) + 1;
  localparam int unsigned CntW = $clog2(DIV_STEPS + 1);

  logic [DIV_W-1:0] quo_q, quo_d, quo_v;
  logic [RemW-1:0]  rem_q, rem_d, rem_v;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;

  // remainder stays below the divisor, so one compare-subtract per bit
  always_comb begin
    rem_v = rem_q;
    quo_v = quo_q;
    for (int k = 0; k < DIV_DIGIT; k++) begin
      rem_v = {rem_v[RemW-2:0], quo_v[DIV_W-1]};
      quo_v = {quo_v[DIV_W-2:0], 1'b0};
      if (rem_v >= RemW'(DIVISOR)) begin
        rem_v    = rem_v - RemW'(DIVISOR);
        quo_v[0] = 1'b1;
      end
    end
    rem_d = rem_v;
    quo_d = quo_v;
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= '0;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntW'(DIV_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

[rtl/core/steering_force_feedback_loop_top.sv]
// Items are taken one at a time: input is not ready again until the result
//   of the last one is loaded; the damping divide (40 quotient bits,
//   4 a cycle) overlaps the last multiplies and ends the sequence.
// A finished result waits in the output register; the next item is taken
//   once the sequencer is back in idle.
// Reset (rst_ni low, async): gains zero, window empty (reads zero), drift
//   point zero, no result pending.
// ----------------------------------------------------------------------------
// Steering force feedback loop - top level
// Spring, damping, rumble and backlash-drift terms on one shared multiplier.
// ----------------------------------------------------------------------------
module steering_force_feedback_loop_top
  import sffl_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = 50,
  parameter int unsigned DRIFT_SPAN = 100000
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input items
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [31:0] wheel_position, [55:32] raw_speed, [72:56] elasticity,
  // [88:73] noise_sample, [95:89] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // result items
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [31:0] drive_current
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // register writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [GAIN_W-1:0]      cfg_data_i
);

  localparam int unsigned SumW  = SPD_W + $clog2(WINDOW_LEN) + 1;
  localparam int unsigned SnapW = $clog2(DRIFT_SPAN + 1);

  // Sequencer: one multiply issued per state from LIM to DRIFT, product read in the next.
  //   LIM   : span * (1 - E)            -> backlash limit
  //   TPROD : |P| * E                   (backlash update from limit)
  //   SLO   : S * t[23:0]               (t = |P| * E)
  //   SHI   : S * t[47:24]
  //   DAMP  : D * |window sum|          (spring term into accumulator)
  //   RUMB  : |N| * R                   (damping product to the divider)
  //   DRIFT : |drift - P| * G           (rumble term)
  //   LAST  :                           (drift term)
  //   DIVW  : wait for quotient and a free output register, add damping, saturate, load output
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LIM,
    ST_TPROD,
    ST_SLO,
    ST_SHI,
    ST_DAMP,
    ST_RUMB,
    ST_DRIFT,
    ST_LAST,
    ST_DIVW
  } state_e;

  state_e state_q;

  // configuration registers
  logic [GAIN_W-1:0] spring_gain_q, damping_gain_q, drift_gain_q;
  logic [RUMB_W-1:0] rumble_amp_q;

  // captured item
  logic signed [POS_W-1:0]   pos_q;
  logic [SPD_W-1:0]          spd_q;
  logic [ELA_W-1:0]          ela_q;
  logic signed [NOISE_W-1:0] noise_q;

  // datapath state
  logic signed [POS_W-1:0] dp_q, dp_d;        // drift point
  logic signed [POS_W:0]   dff_q;             // drift point - P, full width
  logic [MUL_B_W-1:0]      th_q, lo_q;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic                    sneg_q;            // damping term is negative
  logic [OUT_W-1:0]        out_q, out_d;
  logic                    out_vld_q;

  // item fields
  logic              in_acc;
  logic [ELA_W-1:0]  ela_in, ela_clamp;

  // window
  win_ctrl_t               win_ctrl;
  logic signed [SumW-1:0]  win_sum;
  logic signed [MUL_A_W-1:0] sum_ext;
  logic [MUL_A_W-1:0]      sum_mag;
  logic                    sum_pos;

  // multiplier
  logic               mul_en;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] prod;

  // divider
  logic             div_start, div_done;
  logic [DIV_W-1:0] div_quo;

  // magnitudes and signs
  logic [POS_W-1:0]          pos_mag;
  logic                      pos_gt0;
  logic signed [NOISE_W:0]   noise_ext;
  logic [NOISE_W:0]          noise_mag;
  logic [POS_W:0]            dff_mag;

  // backlash
  logic [SnapW-1:0]        snap;
  logic signed [POS_W:0]   snap_x, dp_x, pos_x, diff_w;

  // terms
  logic [49-1:0]           spr_sum;
  logic [40:0]             spr_mag, drf_mag;
  logic [RUMB_W-1:0]       rum_mag;
  logic signed [ACC_W-1:0] spr_s, rum_s, drf_s, dmp_s, tot;
  logic                    tot_ok;

  // --------------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------------
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;
  assign cfg_ready_o   = 1'b1;

  // elasticity above one counts as one
  assign ela_in    = s_axis_tdata[ELA_LSB +: ELA_W];
  assign ela_clamp = (ela_in > ELA_ONE) ? ELA_ONE : ela_in;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spring_gain_q  <= '0;
      damping_gain_q <= '0;
      drift_gain_q   <= '0;
      rumble_amp_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SPRING_GAIN:  spring_gain_q  <= cfg_data_i;
        CFG_DAMPING_GAIN: damping_gain_q <= cfg_data_i;
        CFG_DRIFT_GAIN:   drift_gain_q   <= cfg_data_i;
        CFG_RUMBLE_AMP:   rumble_amp_q   <= cfg_data_i[RUMB_W-1:0];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Speed window: oldest sample read at accept, replaced in LIM
  // --------------------------------------------------------------------------
  assign win_ctrl.rd  = in_acc;
  assign win_ctrl.upd = (state_q == ST_LIM);

  sffl_window #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (win_ctrl),
    .spd_i  (spd_q),
    .sum_o  (win_sum)
  );

  // window sum magnitude stays within 2^31
  assign sum_ext = MUL_A_W'(win_sum);
  assign sum_mag = sum_ext[MUL_A_W-1] ? MUL_A_W'(-sum_ext) : MUL_A_W'(sum_ext);
  assign sum_pos = !win_sum[SumW-1] && (|win_sum);

  // --------------------------------------------------------------------------
  // Operand selection for the shared multiplier
  // --------------------------------------------------------------------------
  assign pos_mag   = pos_q[POS_W-1] ? POS_W'(-pos_q) : POS_W'(pos_q);
  assign pos_gt0   = !pos_q[POS_W-1] && (|pos_q);
  assign noise_ext = (NOISE_W + 1)'(noise_q);
  assign noise_mag = noise_q[NOISE_W-1] ? (NOISE_W + 1)'(-noise_ext)
                                        : (NOISE_W + 1)'(noise_ext);
  assign dff_mag   = dff_q[POS_W] ? (POS_W + 1)'(-dff_q) : (POS_W + 1)'(dff_q);

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      ST_LIM: begin
        mul_a = MUL_A_W'(ELA_ONE - ela_q);
        mul_b = MUL_B_W'(DRIFT_SPAN);
      end
      ST_TPROD: begin
        mul_a = MUL_A_W'(pos_mag);
        mul_b = MUL_B_W'(ela_q);
      end
      ST_SLO: begin
        mul_a = MUL_A_W'(prod[23:0]);
        mul_b = spring_gain_q;
      end
      ST_SHI: begin
        mul_a = MUL_A_W'(th_q);
        mul_b = spring_gain_q;
      end
      ST_DAMP: begin
        mul_a = sum_mag;
        mul_b = damping_gain_q;
      end
      ST_RUMB: begin
        mul_a = MUL_A_W'(noise_mag);
        mul_b = MUL_B_W'(rumble_amp_q);
      end
      ST_DRIFT: begin
        mul_a = dff_mag;
        mul_b = drift_gain_q;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  sffl_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // --------------------------------------------------------------------------
  // Backlash: move drift point only when farther than the snap distance
  // --------------------------------------------------------------------------
  assign snap   = prod[16 +: SnapW];
  assign snap_x = (POS_W + 1)'(snap);
  assign dp_x   = (POS_W + 1)'(dp_q);
  assign pos_x  = (POS_W + 1)'(pos_q);
  assign diff_w = dp_x - pos_x;

  always_comb begin
    if (diff_w > snap_x) begin
      dp_d = pos_q + POS_W'(snap);
    end else if (diff_w < -snap_x) begin
      dp_d = pos_q - POS_W'(snap);
    end else begin
      dp_d = dp_q;
    end
  end

  // --------------------------------------------------------------------------
  // Damping divide by the window length
  // --------------------------------------------------------------------------
  assign div_start = (state_q == ST_RUMB);

  sffl_div #(
    .DIVISOR (WINDOW_LEN)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod[16 +: DIV_W]),
    .quo_o      (div_quo),
    .done_o     (div_done)
  );

  // --------------------------------------------------------------------------
  // Terms, all truncated toward zero by working on magnitudes
  // --------------------------------------------------------------------------
  // spring = floor((S*t_hi + floor(S*t_lo / 2^24)) / 2^8)
  assign spr_sum = {1'b0, prod[47:0]} + 49'(lo_q);
  assign spr_mag = spr_sum[48:8];
  assign spr_s   = pos_gt0 ? -ACC_W'(spr_mag) : ACC_W'(spr_mag);

  assign rum_mag = prod[16 +: RUMB_W];
  assign rum_s   = noise_q[NOISE_W-1] ? -ACC_W'(rum_mag) : ACC_W'(rum_mag);

  assign drf_mag = prod[56:16];
  assign drf_s   = dff_q[POS_W] ? -ACC_W'(drf_mag) : ACC_W'(drf_mag);

  assign dmp_s   = sneg_q ? -ACC_W'(div_quo) : ACC_W'(div_quo);

  always_comb begin
    unique case (state_q)
      ST_DAMP:  acc_d = spr_s;
      ST_DRIFT: acc_d = acc_q + rum_s;
      ST_LAST:  acc_d = acc_q + drf_s;
      default:  acc_d = acc_q;
    endcase
  end

  // saturate to 32-bit signed
  assign tot    = acc_q + dmp_s;
  assign tot_ok = (&tot[ACC_W-1:OUT_W-1]) || !(|tot[ACC_W-1:OUT_W-1]);
  assign out_d  = tot_ok ? tot[OUT_W-1:0]
                         : (tot[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}}
                                         : {1'b0, {(OUT_W-1){1'b1}}});

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pos_q   <= s_axis_tdata[POS_LSB +: POS_W];
      spd_q   <= s_axis_tdata[SPD_LSB +: SPD_W];
      ela_q   <= ela_clamp;
      noise_q <= s_axis_tdata[NOISE_LSB +: NOISE_W];
    end
    unique case (state_q)
      ST_SLO: begin
        th_q  <= prod[47:24];
        dff_q <= diff_w;
      end
      ST_SHI:   lo_q   <= prod[47:24];
      ST_DAMP:  acc_q  <= acc_d;
      ST_RUMB:  sneg_q <= sum_pos;
      ST_DRIFT: acc_q  <= acc_d;
      ST_LAST:  acc_q  <= acc_d;
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer, drift point and output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      dp_q      <= '0;
      out_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= ST_LIM;
          end
        end
        ST_LIM:   state_q <= ST_TPROD;
        ST_TPROD: begin
          dp_q    <= dp_d;
          state_q <= ST_SLO;
        end
        ST_SLO:   state_q <= ST_SHI;
        ST_SHI:   state_q <= ST_DAMP;
        ST_DAMP:  state_q <= ST_RUMB;
        ST_RUMB:  state_q <= ST_DRIFT;
        ST_DRIFT: state_q <= ST_LAST;
        ST_LAST:  state_q <= ST_DIVW;
        ST_DIVW: begin
          if (div_done && (!out_vld_q || m_axis_tready)) begin
            out_q     <= out_d;
            out_vld_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default:  state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/sffl_checker.sv]
// ----------------------------------------------------------------------------
// Steering force feedback loop - port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
`include "steering_force_feedback_loop_top_assert.svh"

module sffl_checker
  import sffl_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // an item in work blocks further input
  `SFFL_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input ready right after an item was taken")

  // a result is only produced by a busy sequencer
  `SFFL_ASSERT_NOW(a_result_from_busy, clk_i, rst_ni, $rose(m_axis_tvalid), $past(!s_axis_tready), "result appeared while the block was idle")

  // no result can follow an item in the very next cycle
  `SFFL_ASSERT_NXT(a_no_early_result, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid), "result one cycle after accept")

  // stalled result holds
  `SFFL_ASSERT_NXT(a_hold_stalled, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed or dropped")

endmodule

bind steering_force_feedback_loop_top sffl_checker u_sffl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
